/* hdl/dss_pkg.sv */
// ---------------------------------------------------------------------------
// LOOK scheduler package
// Shared widths and the control bundle that the sequencer sends to the
// selection unit.
// ---------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

   // Field widths of the stream items.
   localparam int TRACK_W   = 16;
   localparam int MOVE_W    = 17;
   localparam int RSP_TDATA_W = 40;

   // Control of the selection unit for one scan cycle.
   typedef struct packed {
      logic clear;     // start a new scan, forget the current best entry
      logic eval;      // read data of the store is valid this cycle
      logic phase_up;  // 0: downward sweep, 1: upward sweep
      logic served;    // entry under evaluation has already been served
   } sel_ctl_type;

endpackage

`default_nettype wire

/* hdl/dss_store.sv */
// ---------------------------------------------------------------------------
// LOOK scheduler request store
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dss_store
   import dss_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [TRACK_W-1:0] wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [TRACK_W-1:0] rd_data_ff
);

   logic [TRACK_W-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/dss_sel.sv */
// ---------------------------------------------------------------------------
// LOOK scheduler selection unit
// Compares one stored track per cycle against the head and the best candidate
// so far, and keeps the next track to serve for the current sweep direction.
// ---------------------------------------------------------------------------
`default_nettype none

module dss_sel
   import dss_pkg::*;
#(
   parameter int AW = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sel_ctl_type        ctl,
   input  wire logic [TRACK_W-1:0] head,
   input  wire logic [TRACK_W-1:0] entry_val,
   input  wire logic [AW-1:0]      entry_idx,
   output logic                    found_ff,
   output logic      [TRACK_W-1:0] best_val_ff,
   output logic      [AW-1:0]      best_idx_ff
);

   logic               found_in;
   logic [TRACK_W-1:0] best_val_in;
   logic [AW-1:0]      best_idx_in;
   logic               qualifies;
   logic               better;

   // Downward sweep takes the highest unserved track below the head, the
   // upward sweep the lowest unserved track at or above the head.
   always_comb begin
      if (ctl.phase_up) begin
         qualifies = !ctl.served && (entry_val >= head);
         better    = !found_ff || (entry_val < best_val_ff);
      end else begin
         qualifies = !ctl.served && (entry_val < head);
         better    = !found_ff || (entry_val > best_val_ff);
      end
   end

   // Update of the best candidate.
   always_comb begin
      found_in    = found_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.eval && qualifies && better) begin
         found_in    = 1'b1;
         best_val_in = entry_val;
         best_idx_in = entry_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
   end

endmodule

`default_nettype wire

/* hdl/disk_scan_look_scheduler_top.sv */
// ---------------------------------------------------------------------------
// The batch-closing request item starts scheduling. Each result costs one scan of
// the store (one store read per cycle), plus one extra scan when the sweep turns
// upward. No item is taken while a batch is being scheduled.
// Reset (synchronous, active high) empties the batch and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module disk_scan_look_scheduler_top
   import dss_pkg::*;
#(
   parameter int MAX_REQUESTS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [TRACK_W-1:0]     req_tdata,   // [15:0] track
   input  wire logic                   req_tlast,   // last_request
   // Result stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] served_track,
                                                    // [32:16] total_movement,
                                                    // [39:33] zero
   output logic                        rsp_tuser,   // [0] overflow
   output logic                        rsp_tlast    // last_result
);

   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_PICK = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]           count_ff, count_in;
   logic [TRACK_W-1:0]      head_ff, head_in;
   logic                    dropped_ff, dropped_in;
   logic                    solo_ff, solo_in;
   logic                    phase_up_ff, phase_up_in;
   logic [MAX_REQUESTS-1:0] served_ff, served_in;
   logic [CW-1:0]           emitted_ff, emitted_in;
   logic [TRACK_W-1:0]      pos_ff, pos_in;
   logic [MOVE_W-1:0]       move_ff, move_in;
   logic [CW-1:0]           addr_ff, addr_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TRACK_W-1:0]      rsp_track_ff, rsp_track_in;
   logic [MOVE_W-1:0]       rsp_move_ff, rsp_move_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    wr_en;
   logic [TRACK_W-1:0]      rd_data;
   sel_ctl_type             sel_ctl;
   logic                    found;
   logic [TRACK_W-1:0]      best_val;
   logic [AW-1:0]           best_idx;
   logic [CW-1:0]           count_m1;
   logic [CW-1:0]           emitted_p1;
   logic [TRACK_W-1:0]      emit_track;
   logic [TRACK_W-1:0]      step_dist;
   logic                    emit_last;
   logic                    scan_done;
   logic                    rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign count_m1   = count_ff - CW'(1);
   assign emitted_p1 = emitted_ff + CW'(1);
   assign scan_done  = rd_vld_ff && (rd_idx_ff == count_m1);

   // The store takes an item only while there is room left.
   assign wr_en = req_xfer && (count_ff < CW'(MAX_REQUESTS));

   dss_store #(
      .DEPTH (MAX_REQUESTS),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (req_tdata),
      .rd_addr    (addr_ff[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   dss_sel #(
      .AW (AW)
   ) u_sel (
      .clock       (clock),
      .reset       (reset),
      .ctl         (sel_ctl),
      .head        (head_ff),
      .entry_val   (rd_data),
      .entry_idx   (rd_idx_ff[AW-1:0]),
      .found_ff    (found),
      .best_val_ff (best_val),
      .best_idx_ff (best_idx)
   );

   // Result of the current emission: the head alone for a head-only batch.
   always_comb begin
      emit_track = solo_ff ? head_ff : best_val;
      step_dist  = (pos_ff > emit_track) ? (pos_ff - emit_track) : (emit_track - pos_ff);
      emit_last  = solo_ff || (emitted_p1 == count_m1);
   end

   // Sequencer: loading, scans of the store, and emission of results.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      dropped_in   = dropped_ff;
      solo_in      = solo_ff;
      phase_up_in  = phase_up_ff;
      served_in    = served_ff;
      emitted_in   = emitted_ff;
      pos_in       = pos_ff;
      move_in      = move_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = addr_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_track_in = rsp_track_ff;
      rsp_move_in  = rsp_move_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      sel_ctl.clear    = 1'b0;
      sel_ctl.eval     = rd_vld_ff;
      sel_ctl.phase_up = phase_up_ff;
      sel_ctl.served   = served_ff[rd_idx_ff[AW-1:0]];

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (count_ff == '0) begin
                  head_in = req_tdata;
               end
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  // The head is stored first; mark it served so that only
                  // the other requests are visited.
                  solo_in       = (count_ff == '0);
                  phase_up_in   = 1'b0;
                  served_in     = MAX_REQUESTS'(1);
                  emitted_in    = '0;
                  pos_in        = (count_ff == '0) ? req_tdata : head_ff;
                  move_in       = '0;
                  addr_in       = '0;
                  sel_ctl.clear = 1'b1;
                  state_in      = (count_ff == '0) ? S_EMIT : S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (addr_ff < count_ff) begin
               addr_in   = addr_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (scan_done) begin
               state_in = S_PICK;
            end
         end

         S_PICK: begin
            if (found) begin
               state_in = S_EMIT;
            end else if (!phase_up_ff) begin
               // Nothing left below the head: turn and sweep upward.
               phase_up_in   = 1'b1;
               addr_in       = '0;
               sel_ctl.clear = 1'b1;
               state_in      = S_SCAN;
            end else begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = S_IDLE;
            end
         end

         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_track_in = emit_track;
               rsp_move_in  = move_ff + MOVE_W'(step_dist);
               rsp_ovf_in   = dropped_ff;
               rsp_last_in  = emit_last;
               move_in      = move_ff + MOVE_W'(step_dist);
               pos_in       = emit_track;
               emitted_in   = emitted_p1;
               served_in[best_idx] = 1'b1;
               if (emit_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  addr_in       = '0;
                  sel_ctl.clear = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         dropped_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         dropped_ff   <= dropped_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      solo_ff      <= solo_in;
      phase_up_ff  <= phase_up_in;
      served_ff    <= served_in;
      emitted_ff   <= emitted_in;
      pos_ff       <= pos_in;
      move_ff      <= move_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_track_ff <= rsp_track_in;
      rsp_move_ff  <= rsp_move_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Result port.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - MOVE_W - TRACK_W)'(0), rsp_move_ff, rsp_track_ff};
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* dv/disk_scan_look_scheduler_top_tb.sv */
// ---------------------------------------------------------------------------
// LOOK disk scheduler testbench
// Streams batches of track requests into the scheduler and checks every
// served track, the running head movement, the overflow flag and the batch
// end marker. A directed table comes first, then random batches of mixed
// sizes and track patterns. Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module disk_scan_look_scheduler_top_tb
   import dss_pkg::*;
();

   localparam int BATCH_ROOM       = 16;
   localparam int TOTAL_ITEMS      = 430;
   localparam int TAIL_ITEMS       = 60;
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int QUIET_BATCH      = 40;
   localparam int DRAIN_CYCLES     = 200;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int NUM_DIRECTED     = 27;

   // One served request as it leaves the scheduler.
   typedef struct packed {
      logic [TRACK_W-1:0] trk;
      logic [MOVE_W-1:0]  moved;
      logic               ovf;
      logic               lst;
   } service_type;

   // One row of the directed table; typed rows carry their single result.
   typedef struct packed {
      logic [TRACK_W-1:0] trk;
      logic               lst;
      logic               typed;
      service_type        want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TRACK_W-1:0]     req_tdata = '0;   // [15:0] track
   logic                   req_tlast = 1'b0; // last_request
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [15:0] served_track, [32:16] total_movement
   logic                   rsp_tuser;        // [0] overflow
   logic                   rsp_tlast;        // last_result

   // Batch state of the predictor.
   logic [TRACK_W-1:0] batch_tracks [BATCH_ROOM];
   int                 batch_count = 0;
   logic [TRACK_W-1:0] batch_head = '0;
   logic               batch_dropped = 1'b0;

   service_type look_out [$];
   service_type service_q [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          accepted_reqs = 0;
   int          idle_cycles = 0;
   bit          quiet_tail = 1'b0;

   // Receiver idling state.
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   int unsigned rsp_stall_odds = 0;
   bit          long_hold_done = 1'b0;

   // Directed table: extremes, a duplicate head, and a batch that overflows
   // with its closing item being the dropped one.
   stim_row_type dir_rows [NUM_DIRECTED] = '{
      '{16'd0,     1'b1, 1'b1, '{16'd0,     17'd0,     1'b0, 1'b1}},
      '{16'd65535, 1'b1, 1'b1, '{16'd65535, 17'd0,     1'b0, 1'b1}},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b1, 1'b1, '{16'd0,     17'd65535, 1'b0, 1'b1}},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b1, 1'b1, '{16'd65535, 17'd65535, 1'b0, 1'b1}},
      '{16'd1000,  1'b0, 1'b0, '0},
      '{16'd1000,  1'b0, 1'b0, '0},
      '{16'd200,   1'b0, 1'b0, '0},
      '{16'd1500,  1'b1, 1'b0, '0},
      '{16'd30000, 1'b0, 1'b0, '0},
      '{16'd40000, 1'b0, 1'b0, '0},
      '{16'd10000, 1'b0, 1'b0, '0},
      '{16'd30000, 1'b0, 1'b0, '0},
      '{16'd5,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd12345, 1'b0, 1'b0, '0},
      '{16'd54321, 1'b0, 1'b0, '0},
      '{16'd30001, 1'b0, 1'b0, '0},
      '{16'd29999, 1'b0, 1'b0, '0},
      '{16'd100,   1'b0, 1'b0, '0},
      '{16'd60000, 1'b0, 1'b0, '0},
      '{16'd7,     1'b0, 1'b0, '0},
      '{16'd7,     1'b0, 1'b0, '0},
      '{16'd8,     1'b0, 1'b0, '0},
      '{16'd9,     1'b1, 1'b0, '0}
   };

   disk_scan_look_scheduler_top #(.MAX_REQUESTS(BATCH_ROOM)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Stores one request and, on the closing one, works out the LOOK order:
   // down from the head to the lowest track, then up to the highest.
   function automatic void predict_look(input logic [TRACK_W-1:0] trk, input logic lst);
      logic [TRACK_W-1:0] order [BATCH_ROOM];
      logic [TRACK_W-1:0] v;
      logic [TRACK_W-1:0] at;
      logic [TRACK_W-1:0] t;
      logic [MOVE_W-1:0]  moved;
      int                 n;
      int                 i;
      int                 j;
      int                 hit;
      look_out.delete();
      if (batch_count == 0) batch_head = trk;
      if (batch_count < BATCH_ROOM) begin
         batch_tracks[batch_count] = trk;
         batch_count++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (!lst) return;

      // Insertion sort of the stored tracks.
      n = batch_count;
      for (i = 0; i < n; i++) order[i] = batch_tracks[i];
      for (i = 1; i < n; i++) begin
         v = order[i];
         j = i;
         while (j > 0 && order[j-1] > v) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end

      // The head sits at its first match in sorted order.
      hit = 0;
      for (i = n - 1; i >= 0; i--) if (order[i] == batch_head) hit = i;

      if (n == 1) begin
         look_out.push_back('{batch_head, '0, batch_dropped, 1'b1});
      end else begin
         at = batch_head;
         moved = '0;
         // Steps below hit walk downward; the rest walk upward past the head.
         for (j = 0; j < n - 1; j++) begin
            t = (j < hit) ? order[hit-1-j] : order[j+1];
            moved = moved + {1'b0, (at > t) ? at - t : t - at};
            at = t;
            look_out.push_back('{t, moved, batch_dropped, j == n - 2});
         end
      end
      batch_count = 0;
      batch_dropped = 1'b0;
   endfunction

   // Counts a mismatch and prints one line for it.
   task automatic report_mismatch(input string what, input logic [RSP_TDATA_W-1:0] got,
                                  input logic [RSP_TDATA_W-1:0] want);
      mismatches++;
      $display("mismatch in %s: got %0d, want %0d", what, got, want);
   endtask

   // Offers one request, optionally after an idle burst, and records what it
   // should cause once the transfer has taken place.
   task automatic send_request(input logic [TRACK_W-1:0] trk, input logic lst,
                               input logic typed, input service_type want, input bit may_idle);
      if (may_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= trk;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_look(trk, lst);
      if (typed) begin
         service_q.push_back(want);
      end else begin
         foreach (look_out[k]) service_q.push_back(look_out[k]);
      end
      items_sent++;
   endtask

   // Result receiver: random stall bursts, calm stretches, and one long
   // hold-off that backs the scheduler up into its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && accepted_reqs >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD_CYCLES;
         rsp_tready     <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < rsp_stall_odds) begin
         hold_left  <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
      if (mode_left == 0) begin
         mode_left      <= 200;
         rsp_stall_odds <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end else begin
         mode_left <= mode_left - 1;
      end
   end

   // Result checker: each transfer is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      service_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (service_q.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata, '0);
         end else begin
            want = service_q.pop_front();
            if (rsp_tdata[15:0] !== want.trk)
               report_mismatch("served_track", rsp_tdata[15:0], want.trk);
            if (rsp_tdata[32:16] !== want.moved)
               report_mismatch("total_movement", rsp_tdata[32:16], want.moved);
            if (rsp_tdata[RSP_TDATA_W-1:33] !== '0)
               report_mismatch("tdata padding", rsp_tdata[RSP_TDATA_W-1:33], '0);
            if (rsp_tuser !== want.ovf)
               report_mismatch("overflow", rsp_tuser, want.ovf);
            if (rsp_tlast !== want.lst)
               report_mismatch("last_result", rsp_tlast, want.lst);
         end
      end
      if (!reset && req_tvalid && req_tready) accepted_reqs <= accepted_reqs + 1;
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed table, then random batches, then drain.
   initial begin
      int unsigned        i;
      int unsigned        n;
      int unsigned        r;
      int unsigned        pattern;
      int unsigned        batch_no;
      bit                 calm;
      logic [TRACK_W-1:0] base;
      logic [TRACK_W-1:0] trk;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++)
         send_request(dir_rows[i].trk, dir_rows[i].lst, dir_rows[i].typed,
                      dir_rows[i].want, 1'b1);

      batch_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         // Mostly short batches, some up to capacity, a few that overflow.
         r = $urandom_range(0, 9);
         if (r < 7)      n = $urandom_range(1, 6);
         else if (r < 9) n = $urandom_range(7, 16);
         else            n = $urandom_range(17, 20);
         pattern = $urandom_range(0, 3);
         base    = TRACK_W'($urandom);
         calm    = ($urandom_range(0, 2) == 0);
         if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;

         // Once, let the scheduler drain completely before going on.
         if (batch_no == QUIET_BATCH && service_q.size() != 0) begin
            req_tvalid <= 1'b0;
            while (service_q.size() != 0) @(posedge clock);
         end

         for (i = 0; i < n; i++) begin
            case (pattern)
               0: trk = TRACK_W'($urandom);
               1: trk = base + TRACK_W'($urandom_range(0, 7));
               2: begin
                  case ($urandom_range(0, 2))
                     0:       trk = '0;
                     1:       trk = '1;
                     default: trk = TRACK_W'($urandom);
                  endcase
               end
               default: trk = TRACK_W'($urandom_range(0, 255));
            endcase
            send_request(trk, i == n - 1, 1'b0, '0, !calm && !quiet_tail);
         end
         batch_no++;
      end
      req_tvalid <= 1'b0;

      while (service_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
